FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define QTE_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("qte assertion failed");

// Implication within the same cycle.
`define QTE_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("qte assertion failed");

`endif

FILE: hdl/qte_pkg.sv
// Package for the quaternion to Euler angle pipeline: types, constants, helpers.
package qte_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int TW = 36;  // term width
  localparam int VW = 40;  // CORDIC vector width
  localparam int AW = 33;  // angle accumulator width

  localparam logic signed [AW-1:0] HALF_PI_Q29 = 33'sd843314857;
  localparam logic signed [AW-1:0] PI_Q29      = 33'sd1686629713;
  localparam logic signed [TW-1:0] ONE_Q30     = 36'sd1073741824;

  typedef struct packed {
    logic signed [TW-1:0] t0;
    logic signed [TW-1:0] t1;
    logic signed [TW-1:0] t2;  // saturated
    logic signed [TW-1:0] t3;
    logic signed [TW-1:0] t4;
  } terms_t;

  typedef struct packed {
    logic        v;
    logic [63:0] n;
    logic [63:0] res;
    terms_t      t;
  } sqs_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [AW-1:0] ang;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    logic v;
    vec_t p;
    vec_t r;
    vec_t w;  // yaw
  } trio_t;

  function automatic logic signed [AW-1:0] atan_q29(input logic [4:0] i);
    logic signed [AW-1:0] a;
    case (i)
      5'd0:  a = 33'sd421657428;
      5'd1:  a = 33'sd248918915;
      5'd2:  a = 33'sd131521918;
      5'd3:  a = 33'sd66762579;
      5'd4:  a = 33'sd33510843;
      5'd5:  a = 33'sd16771758;
      5'd6:  a = 33'sd8387925;
      5'd7:  a = 33'sd4194219;
      5'd8:  a = 33'sd2097141;
      5'd9:  a = 33'sd1048575;
      5'd30: a = 33'sd0;
      5'd31: a = 33'sd0;
      default: a = AW'(64'sd1 <<< (29 - 32'(i)));
    endcase
    return a;
  endfunction

  // Quadrant fold ahead of the micro-rotations.
  function automatic vec_t prerot(input logic signed [TW-1:0] y,
                                  input logic signed [TW-1:0] x);
    vec_t o;
    o.zero = (x == '0) && (y == '0);
    o.x    = VW'(x);
    o.y    = VW'(y);
    o.ang  = '0;
    if (x < 0) begin
      if (y >= 0) begin
        o.x   = VW'(y);
        o.y   = -VW'(x);
        o.ang = HALF_PI_Q29;
      end else begin
        o.x   = -VW'(y);
        o.y   = VW'(x);
        o.ang = -HALF_PI_Q29;
      end
    end
    return o;
  endfunction

  function automatic logic signed [AW-1:0] clampa(input logic signed [AW-1:0] a,
                                                  input logic signed [AW-1:0] lim);
    logic signed [AW-1:0] o;
    o = a;
    if (a > lim) o = lim;
    if (a < -lim) o = -lim;
    return o;
  endfunction

endpackage

FILE: hdl/qte_terms.sv
// Front end: component products, matrix terms, pitch saturation and 1 - t^2.
module qte_terms import qte_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  logic signed [31:0] w,
  input  logic signed [31:0] x,
  input  logic signed [31:0] y,
  input  logic signed [31:0] z,
  output sqs_t               out
);
  logic signed [63:0] xx_r, yy_r, zz_r, xy_r, wz_r, wy_r, xz_r, yz_r, wx_r;
  logic               v1_r, v2_r, v3_r;
  terms_t             t2_r, t3_r;
  terms_t             t_nxt;
  logic signed [63:0] sq_r;
  logic signed [TW-1:0] yyq, raw2;

  always_comb begin
    yyq        = TW'(yy_r >>> 29);
    t_nxt.t0   = ONE_Q30 - (yyq + TW'(zz_r >>> 29));
    t_nxt.t1   = TW'(xy_r >>> 29) + TW'(wz_r >>> 29);
    raw2       = TW'(wy_r >>> 29) - TW'(xz_r >>> 29);
    t_nxt.t2   = raw2;
    if (raw2 > ONE_Q30) t_nxt.t2 = ONE_Q30;
    if (raw2 < -ONE_Q30) t_nxt.t2 = -ONE_Q30;
    t_nxt.t3   = TW'(yz_r >>> 29) + TW'(wx_r >>> 29);
    t_nxt.t4   = ONE_Q30 - (TW'(xx_r >>> 29) + yyq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      out.v <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      out.v <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= x * x;  yy_r <= y * y;  zz_r <= z * z;
      xy_r <= x * y;  wz_r <= w * z;  wy_r <= w * y;
      xz_r <= x * z;  yz_r <= y * z;  wx_r <= w * x;
      t2_r <= t_nxt;
      // saturated term fits 32 bits signed; square it signed
      sq_r <= $signed(t2_r.t2[31:0]) * $signed(t2_r.t2[31:0]);
      t3_r <= t2_r;
      out.n   <= (64'd1 << 60) - 64'(sq_r);
      out.res <= '0;
      out.t   <= t3_r;
    end
  end
endmodule

FILE: hdl/qte_sqrt_cell.sv
// One digit step of the integer square root, with side terms carried along.
module qte_sqrt_cell import qte_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [4:0] k,   // bit = 4^(31-k)
  input  sqs_t       din,
  output sqs_t       dout
);
  logic [63:0] bitv, trial;
  sqs_t        d_nxt;

  always_comb begin
    bitv  = 64'd1 << (7'd62 - {k, 1'b0});
    trial = din.res + bitv;
    d_nxt = din;
    if (din.n >= trial) begin
      d_nxt.n   = din.n - trial;
      d_nxt.res = (din.res >> 1) + bitv;
    end else begin
      d_nxt.res = din.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dout.v <= 1'b0;
    else if (en) dout.v <= din.v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.n   <= d_nxt.n;
      dout.res <= d_nxt.res;
      dout.t   <= d_nxt.t;
    end
  end
endmodule

FILE: hdl/qte_cordic_cell.sv
// One vectoring micro-rotation for the pitch, roll and yaw vectors.
module qte_cordic_cell import qte_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [4:0] i,
  input  trio_t      din,
  output trio_t      dout
);
  logic signed [AW-1:0] a;
  trio_t d_nxt;

  function automatic vec_t rot(input vec_t v, input logic [4:0] s,
                               input logic signed [AW-1:0] da);
    vec_t o;
    o = v;
    if (v.y >= 0) begin
      o.x   = v.x + (v.y >>> s);
      o.y   = v.y - (v.x >>> s);
      o.ang = v.ang + da;
    end else begin
      o.x   = v.x - (v.y >>> s);
      o.y   = v.y + (v.x >>> s);
      o.ang = v.ang - da;
    end
    return o;
  endfunction

  always_comb begin
    a       = atan_q29(i);
    d_nxt.v = din.v;
    d_nxt.p = rot(din.p, i, a);
    d_nxt.r = rot(din.r, i, a);
    d_nxt.w = rot(din.w, i, a);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dout.v <= 1'b0;
    else if (en) dout.v <= d_nxt.v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.p <= d_nxt.p;
      dout.r <= d_nxt.r;
      dout.w <= d_nxt.w;
    end
  end
endmodule

FILE: hdl/quaternion_to_euler_angles.sv
// Top level: quaternion (Q1.30) to Z-Y-X Euler angles (Q3.29) pipeline.
//
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    q_w, q_x, q_y, q_z
// out_     out  out_tvalid/out_tready  pitch, roll, yaw
//
// One request per clock while out_ is not stalled; registered in order through the
// front end, square root digit cells, quadrant fold, rotation cells and clamp.
// The whole pipe advances together whenever the output register is empty or
// being taken, so a stall at out_ holds every stage and in_tready drops.
// Reset clears only the valid bits; payload registers carry no reset.
`include "assert_macros.svh"
module quaternion_to_euler_angles import qte_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // q_w[31:0], q_x[63:32], q_y[95:64], q_z[127:96]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata   // pitch[30:0], roll[62:31], yaw[94:63], zero pad
);
  logic  adv;
  sqs_t  sq [SQRT_STEPS+1];
  trio_t cr [CORDIC_STEPS+1];
  logic  out_v_r;
  logic signed [30:0] pitch_r;
  logic signed [31:0] roll_r, yaw_r;
  logic signed [AW-1:0] pa, ra, ya;

  // global advance: output free or being drained
  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv;

  qte_terms u_terms (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_v(in_tvalid),
    .w(in_tdata[31:0]), .x(in_tdata[63:32]),
    .y(in_tdata[95:64]), .z(in_tdata[127:96]),
    .out(sq[0])
  );

  // cos(pitch) = floor(sqrt(1 - t2^2)), one result bit per cell
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    qte_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv), .k(5'(k)),
      .din(sq[k]), .dout(sq[k+1])
    );
  end

  // quadrant fold: result lands in cr[0]
  always_ff @(posedge clk) begin
    if (!rst_n) cr[0].v <= 1'b0;
    else if (adv) cr[0].v <= sq[SQRT_STEPS].v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cr[0].p <= prerot(sq[SQRT_STEPS].t.t2, TW'(sq[SQRT_STEPS].res[30:0]));
      cr[0].r <= prerot(sq[SQRT_STEPS].t.t3, sq[SQRT_STEPS].t.t4);
      cr[0].w <= prerot(sq[SQRT_STEPS].t.t1, sq[SQRT_STEPS].t.t0);
    end
  end

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
    qte_cordic_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv), .i(5'(s)),
      .din(cr[s]), .dout(cr[s+1])
    );
  end

  // zero vector gives zero angle; then clamp to range
  always_comb begin
    pa = cr[CORDIC_STEPS].p.zero ? '0 : clampa(cr[CORDIC_STEPS].p.ang, HALF_PI_Q29);
    ra = cr[CORDIC_STEPS].r.zero ? '0 : clampa(cr[CORDIC_STEPS].r.ang, PI_Q29);
    ya = cr[CORDIC_STEPS].w.zero ? '0 : clampa(cr[CORDIC_STEPS].w.ang, PI_Q29);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (adv) out_v_r <= cr[CORDIC_STEPS].v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pitch_r <= pa[30:0];
      roll_r  <= ra[31:0];
      yaw_r   <= ya[31:0];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, yaw_r, roll_r, pitch_r};

  `QTE_ASSERT_IMP(a_pitch_rng, out_tvalid,
    (pitch_r <= 31'sd843314857) && (pitch_r >= -31'sd843314857))
  `QTE_ASSERT_IMP(a_roll_rng, out_tvalid,
    (roll_r <= 32'sd1686629713) && (roll_r >= -32'sd1686629713))
  `QTE_ASSERT_IMP(a_yaw_rng, out_tvalid,
    (yaw_r <= 32'sd1686629713) && (yaw_r >= -32'sd1686629713))
endmodule
